### hw/rtl/pcx_rle_pkg.sv
// Shared types and constants for the PCX run-length scanline decoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package pcx_rle_pkg;

	// Byte classification
	localparam logic [7:0] PREFIX_MASK = 8'hC0;
	localparam logic [7:0] RUN_MASK    = 8'h3F;

	// Configuration register indexes
	localparam logic REG_LINE_LENGTH = 1'b0;
	localparam logic REG_LINE_TOTAL  = 1'b1;

	// Register reset values
	localparam logic [15:0] LINE_LENGTH_RESET = 16'd320;
	localparam logic [15:0] LINE_TOTAL_RESET  = 16'd200;

	// Default depth of the command queue between front and back end
	localparam int QUEUE_DEPTH_DEFAULT = 2;

	// One classified command: a pixel value, how often to repeat it, and
	// whether the image state must be cleared before it is carried out
	typedef struct packed {
		logic [7:0] code;
		logic [5:0] run;
		logic       start;
	} cmd_t;

	// Front end to queue
	typedef struct packed {
		logic push;
		cmd_t cmd;
	} push_t;

	// Queue to back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

endpackage

### hw/rtl/pcx_rle_scanline_decoder.sv
// PCX run-length scanline decoder, top level: configuration registers,
// front end, command queue and back end. Depends on pcx_rle_pkg.
`timescale 1ns / 1ps

// Decodes a PCX compressed image body one byte at a time into pixel bytes,
// flagging the end of each scanline, the end of the image and the last
// pixel caused by each input byte. A count prefix byte is accepted and
// produces no pixel. The front end accepts one byte per cycle while the
// command queue has room; the back end takes a command from the queue
// only once the previous run is done and expands it at one pixel per
// cycle while the pixel channel is not stalled. Pixels after the final
// scanline are dropped. line_length (index 0) and line_total (index 1)
// are written through the configuration channel, which is always ready,
// and should be changed only while the decoder is idle.

module pcx_rle_scanline_decoder #(
	parameter int QUEUE_DEPTH = pcx_rle_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// compressed byte channel
	input  logic        code_valid,
	output logic        code_stall,
	input  logic [7:0]  code_byte,
	input  logic        image_start,
	// pixel channel
	output logic        pix_valid,
	input  logic        pix_stall,
	output logic [7:0]  pixel,
	output logic        line_end,
	output logic        image_end,
	output logic        last,
	// configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0]        line_length_q;
	logic [15:0]        line_total_q;
	pcx_rle_pkg::push_t push;
	pcx_rle_pkg::head_t head;
	logic               queue_full;
	logic               pop;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= pcx_rle_pkg::LINE_LENGTH_RESET;
			line_total_q  <= pcx_rle_pkg::LINE_TOTAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pcx_rle_pkg::REG_LINE_LENGTH: line_length_q <= cfg_data;
				pcx_rle_pkg::REG_LINE_TOTAL:  line_total_q  <= cfg_data;
				default:                      line_length_q <= line_length_q;
			endcase
		end
	end

	pcx_rle_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.code_valid  (code_valid),
		.code_stall  (code_stall),
		.code_byte   (code_byte),
		.image_start (image_start),
		.queue_full  (queue_full),
		.push        (push)
	);

	pcx_rle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (queue_full),
		.head   (head),
		.pop    (pop)
	);

	pcx_rle_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.line_length (line_length_q),
		.line_total  (line_total_q),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.pixel       (pixel),
		.line_end    (line_end),
		.image_end   (image_end),
		.last        (last)
	);

endmodule

### hw/rtl/pcx_rle_front.sv
// Front end: accepts compressed bytes, tracks count prefixes and issues
// run commands. Depends on pcx_rle_pkg.
`timescale 1ns / 1ps

module pcx_rle_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                code_valid,
	output logic                code_stall,
	input  logic [7:0]          code_byte,
	input  logic                image_start,
	input  logic                queue_full,
	output pcx_rle_pkg::push_t  push
);

	logic       count_pending_q;
	logic [5:0] pending_run_q;
	logic       accept;
	logic       pend;
	logic [5:0] prun;
	logic       is_prefix;

	assign code_stall = queue_full;
	assign accept     = code_valid && !code_stall;

	// Start drops any prefix still waiting for its value byte
	assign pend      = image_start ? 1'b0 : count_pending_q;
	assign prun      = image_start ? 6'd0 : pending_run_q;
	assign is_prefix = (code_byte & pcx_rle_pkg::PREFIX_MASK) == pcx_rle_pkg::PREFIX_MASK;

	// Classify the byte and build the command
	always_comb begin
		push.push      = 1'b0;
		push.cmd.code  = code_byte;
		push.cmd.start = image_start;
		push.cmd.run   = 6'd1;
		if (accept) begin
			if (pend) begin
				push.cmd.run = prun;
				push.push    = (prun != 6'd0) || image_start;
			end else if (is_prefix) begin
				// prefix gives no pixels; pass the clear on only
				push.cmd.run = 6'd0;
				push.push    = image_start;
			end else begin
				push.push = 1'b1;
			end
		end
	end

	// Hold prefix state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_pending_q <= 1'b0;
			pending_run_q   <= 6'd0;
		end else if (accept) begin
			if (!pend && is_prefix) begin
				count_pending_q <= 1'b1;
				pending_run_q   <= code_byte[5:0] & pcx_rle_pkg::RUN_MASK[5:0];
			end else begin
				count_pending_q <= 1'b0;
				pending_run_q   <= 6'd0;
			end
		end
	end

endmodule

### hw/rtl/pcx_rle_queue.sv
// Short command queue decoupling the front end from the back end.
// Depends on pcx_rle_pkg.
`timescale 1ns / 1ps

module pcx_rle_queue #(
	parameter int DEPTH = pcx_rle_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pcx_rle_pkg::push_t  push,
	output logic                full,
	output pcx_rle_pkg::head_t  head,
	input  logic                pop
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	pcx_rle_pkg::cmd_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = count_q == CW'(DEPTH);
	assign head.valid = count_q != '0;
	assign head.cmd   = entry_q[rd_ptr_q];
	assign do_push    = push.push && !full;
	assign do_pop     = pop && head.valid;

	// Store the incoming command
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |-> !full)
		else $error("command pushed into a full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue occupancy beyond depth");

	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		full && do_pop && !push.push |=> !full)
		else $error("pop from full queue did not free an entry");
`endif

endmodule

### hw/rtl/pcx_rle_back.sv
// Back end: expands run commands into pixels, counts columns and rows and
// holds the result in an output register. Depends on pcx_rle_pkg.
`timescale 1ns / 1ps

module pcx_rle_back (
	input  logic                clk,
	input  logic                arst_n,
	input  pcx_rle_pkg::head_t  head,
	output logic                pop,
	input  logic [15:0]         line_length,
	input  logic [15:0]         line_total,
	output logic                pix_valid,
	input  logic                pix_stall,
	output logic [7:0]          pixel,
	output logic                line_end,
	output logic                image_end,
	output logic                last
);

	logic        active_q;
	logic [7:0]  code_q;
	logic [5:0]  remaining_q;
	logic [15:0] column_q;
	logic [15:0] row_q;
	logic        done_q;
	logic        out_valid_q;

	logic        can_load;
	logic        emit;
	logic [16:0] col_inc;
	logic [16:0] row_inc;
	logic        le;
	logic        ie;
	logic        lst;

	assign can_load = !out_valid_q || !pix_stall;
	assign pop      = !active_q && head.valid;
	assign emit     = active_q && !done_q && can_load;

	// Line and image completion for the next pixel
	assign col_inc = {1'b0, column_q} + 17'd1;
	assign row_inc = {1'b0, row_q} + 17'd1;
	assign le      = col_inc >= {1'b0, line_length};
	assign ie      = le && (row_inc >= {1'b0, line_total});
	assign lst     = (remaining_q == 6'd1) || ie;

	// Take commands, expand runs, track position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			remaining_q <= 6'd0;
			column_q    <= 16'd0;
			row_q       <= 16'd0;
			done_q      <= 1'b0;
		end else if (pop) begin
			active_q    <= head.cmd.run != 6'd0;
			remaining_q <= head.cmd.run;
			if (head.cmd.start) begin
				column_q <= 16'd0;
				row_q    <= 16'd0;
				done_q   <= 1'b0;
			end
		end else if (active_q && done_q) begin
			// image complete: drop the rest of the run
			active_q <= 1'b0;
		end else if (emit) begin
			remaining_q <= remaining_q - 6'd1;
			if (lst) begin
				active_q <= 1'b0;
			end
			if (le) begin
				column_q <= 16'd0;
				row_q    <= row_inc[15:0];
				if (ie) begin
					done_q <= 1'b1;
				end
			end else begin
				column_q <= col_inc[15:0];
			end
		end
	end

	// Latch the pixel value of the command
	always_ff @(posedge clk) begin
		if (pop) begin
			code_q <= head.cmd.code;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!pix_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			pixel     <= code_q;
			line_end  <= le;
			image_end <= ie;
			last      <= lst;
		end
	end

	assign pix_valid = out_valid_q;

`ifndef SYNTHESIS
	a_image_end_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && image_end |-> line_end)
		else $error("image end without line end");

	a_image_end_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		emit && ie |=> done_q && !active_q)
		else $error("final line did not close the image");

	a_run_ends_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit && lst |=> !active_q)
		else $error("run still active after its last pixel");

	a_no_emit_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && done_q |=> !active_q && !(out_valid_q && !$past(out_valid_q)))
		else $error("pixel produced after image end");
`endif

endmodule

### tb/tb_pcx_rle_scanline_decoder.sv
// Self-checking testbench for pcx_rle_scanline_decoder: a queued byte driver,
// a pixel monitor and an in-bench PCX run-length decoder that predicts pixels.
// Depends on pcx_rle_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_pcx_rle_scanline_decoder;

	localparam int SETTLE_CYCLES = 200;
	localparam int LONG_HOLD     = 400;

	typedef struct packed {
		logic [7:0] code;
		logic       start;
	} code_item_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic       line_end;
		logic       image_end;
		logic       last;
	} pixel_item_t;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        code_valid  = 1'b0;
	logic        code_stall;
	logic [7:0]  code_byte   = 8'h00;
	logic        image_start = 1'b0;
	logic        pix_valid;
	logic        pix_stall   = 1'b0;
	logic [7:0]  pixel;
	logic        line_end;
	logic        image_end;
	logic        last;
	logic        cfg_valid   = 1'b0;
	logic        cfg_ready;
	logic        cfg_index   = pcx_rle_pkg::REG_LINE_LENGTH;
	logic [15:0] cfg_data    = 16'h0000;

	code_item_t  code_q[$];
	pixel_item_t pixel_expect_q[$];

	// Decoder copy: registers and image state
	logic [15:0] line_len = pcx_rle_pkg::LINE_LENGTH_RESET;
	logic [15:0] line_tot = pcx_rle_pkg::LINE_TOTAL_RESET;
	logic        run_pending;
	logic [5:0]  held_run;
	logic [15:0] col_count;
	logic [15:0] row_count;
	logic        image_done;

	int  err_count    = 0;
	int  queued_items = 0;
	bit  calm         = 1'b0;
	bit  want_hold    = 1'b0;
	int  gap_left     = 0;
	int  stall_left   = 0;
	int  hold_left    = 0;
	bit  hold_done    = 1'b0;

	pcx_rle_scanline_decoder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.code_valid  (code_valid),
		.code_stall  (code_stall),
		.code_byte   (code_byte),
		.image_start (image_start),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.pixel       (pixel),
		.line_end    (line_end),
		.image_end   (image_end),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Clear run, line and row state
	task automatic clear_image();
		run_pending = 1'b0;
		held_run    = '0;
		col_count   = '0;
		row_count   = '0;
		image_done  = 1'b0;
	endtask

	// Expand one accepted byte into the pixels it should produce
	task automatic decode_code(input logic [7:0] code, input logic start);
		int          run_len;
		bit          have_prev;
		pixel_item_t prev;
		pixel_item_t cur;
		have_prev = 1'b0;
		prev      = '0;
		if (start)
			clear_image();
		if (run_pending) begin
			run_len     = int'(held_run);
			run_pending = 1'b0;
			held_run    = '0;
		end else if ((code & pcx_rle_pkg::PREFIX_MASK) == pcx_rle_pkg::PREFIX_MASK) begin
			run_pending = 1'b1;
			held_run    = code[5:0] & pcx_rle_pkg::RUN_MASK[5:0];
			return;
		end else begin
			run_len = 1;
		end
		for (int i = 0; i < run_len && !image_done; i++) begin
			cur           = '0;
			cur.pixel     = code;
			if (int'(col_count) + 1 >= int'(line_len)) begin
				cur.line_end = 1'b1;
				col_count    = '0;
				if (int'(row_count) + 1 >= int'(line_tot)) begin
					cur.image_end = 1'b1;
					image_done    = 1'b1;
				end
				row_count = row_count + 16'd1;
			end else begin
				col_count = col_count + 16'd1;
			end
			// hold back one pixel so the final one can take the last flag
			if (have_prev)
				pixel_expect_q.push_back(prev);
			prev      = cur;
			have_prev = 1'b1;
		end
		if (have_prev) begin
			prev.last = 1'b1;
			pixel_expect_q.push_back(prev);
		end
	endtask

	// Byte driver: predict on acceptance, then offer the next queued item
	always @(posedge clk or negedge arst_n) begin
		code_item_t nxt;
		if (!arst_n) begin
			code_valid  <= 1'b0;
			code_byte   <= 8'h00;
			image_start <= 1'b0;
			clear_image();
		end else begin
			if (code_valid && !code_stall)
				decode_code(code_byte, image_start);
			if (!code_valid || !code_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					code_valid <= 1'b0;
				end else if (code_q.size() > 0) begin
					nxt = code_q.pop_front();
					code_valid  <= 1'b1;
					code_byte   <= nxt.code;
					image_start <= nxt.start;
					if (!calm && $urandom_range(0, 5) == 0)
						gap_left = $urandom_range(1, 14);
				end else begin
					code_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
				act_val);
			err_count++;
		end
	endtask

	// Pixel monitor: compare against the oldest expectation, then pick the stall
	always @(posedge clk or negedge arst_n) begin
		pixel_item_t exp_pix;
		if (!arst_n) begin
			pix_stall <= 1'b0;
		end else begin
			if (pix_valid && !pix_stall) begin
				if (pixel_expect_q.size() == 0) begin
					$display("%0t: unexpected pixel, expected none, actual %0h le %0b ie %0b last %0b",
						$time, pixel, line_end, image_end, last);
					err_count++;
				end else begin
					exp_pix = pixel_expect_q.pop_front();
					check_field("pixel", int'(exp_pix.pixel), int'(pixel));
					check_field("line_end", int'(exp_pix.line_end), int'(line_end));
					check_field("image_end", int'(exp_pix.image_end), int'(image_end));
					check_field("last", int'(exp_pix.last), int'(last));
				end
			end
			// one long hold-off so the input side backs up
			if (want_hold && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				pix_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				pix_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				pix_stall <= 1'b1;
			end else begin
				pix_stall <= 1'b0;
			end
		end
	end

	task automatic push_code(input logic [7:0] code, input logic start);
		code_item_t it;
		it.code  = code;
		it.start = start;
		code_q.push_back(it);
		queued_items++;
	endtask

	// Hold until every item is taken and every pixel has arrived, then settle
	task automatic wait_drained();
		while (code_q.size() > 0 || code_valid || pixel_expect_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == pcx_rle_pkg::REG_LINE_LENGTH)
			line_len = val;
		else
			line_tot = val;
	endtask

	function automatic logic [5:0] pick_run();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 6'd0;
		if (r == 1)
			return 6'd63;
		if (r < 8)
			return 6'($urandom_range(1, 8));
		return 6'($urandom_range(0, 63));
	endfunction

	// Queue one random sequence: mostly prefix/value pairs and literals
	task automatic push_sequence();
		int   kind;
		logic start;
		kind  = $urandom_range(0, 99);
		start = ($urandom_range(0, 11) == 0);
		if (kind < 50) begin
			push_code(pcx_rle_pkg::PREFIX_MASK | {2'b00, pick_run()}, start);
			push_code(8'($urandom_range(0, 255)), 1'b0);
		end else if (kind < 88) begin
			push_code(8'($urandom_range(0, 191)), start);
		end else if (kind < 94) begin
			// lone prefix: the next sequence's first byte becomes its value
			push_code(pcx_rle_pkg::PREFIX_MASK | {2'b00, pick_run()}, start);
		end else begin
			push_code(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic run_phase(input logic [15:0] len, input logic [15:0] tot, input int target);
		int base;
		wait_drained();
		write_reg(pcx_rle_pkg::REG_LINE_LENGTH, len);
		write_reg(pcx_rle_pkg::REG_LINE_TOTAL, tot);
		base = queued_items;
		while (queued_items - base < target) begin
			if (code_q.size() < 6)
				push_sequence();
			else
				@(posedge clk);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: literals, zero run, full run, prefix-like values, restart
		push_code(8'h00, 1'b1);
		push_code(8'hBF, 1'b0);
		push_code(8'h7F, 1'b0);
		push_code(8'hC0, 1'b0);
		push_code(8'h55, 1'b0);
		push_code(8'hFF, 1'b0);
		push_code(8'hFF, 1'b0);
		push_code(8'hC2, 1'b0);
		push_code(8'hC7, 1'b0);
		push_code(8'hC5, 1'b0);
		push_code(8'h12, 1'b1);
		wait_drained();

		// Tiny image: runs across lines, a run hitting the image end, dropped bytes
		write_reg(pcx_rle_pkg::REG_LINE_LENGTH, 16'd3);
		write_reg(pcx_rle_pkg::REG_LINE_TOTAL, 16'd2);
		push_code(8'hC4, 1'b1);
		push_code(8'hA5, 1'b0);
		push_code(8'hC9, 1'b0);
		push_code(8'h3C, 1'b0);
		push_code(8'h01, 1'b0);
		push_code(8'hC3, 1'b0);
		push_code(8'h77, 1'b0);
		push_code(8'h80, 1'b1);

		// Random phases over several line shapes, extremes included
		run_phase(16'd1, 16'd65535, 30);
		wait_drained();
		want_hold = 1'b1;
		run_phase(16'd65535, 16'd65535, 30);
		run_phase(16'd1, 16'd1, 10);
		run_phase(16'd7, 16'd5, 40);
		run_phase(16'd16, 16'd3, 40);
		run_phase(16'd2, 16'd40, 40);
		wait_drained();
		calm = 1'b1;
		run_phase(16'd5, 16'd4, 30);
		wait_drained();

		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Backstop against a hung handshake
	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

### sim.f
hw/rtl/pcx_rle_pkg.sv
hw/rtl/pcx_rle_front.sv
hw/rtl/pcx_rle_queue.sv
hw/rtl/pcx_rle_back.sv
hw/rtl/pcx_rle_scanline_decoder.sv
tb/tb_pcx_rle_scanline_decoder.sv
